### src/assert_macros.svh
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

### src/r2fft_pkg.sv
// ----------------------------------------------------------------------------
// r2fft_pkg
// Constants, types and the twiddle table of the radix-2 FFT.
// ----------------------------------------------------------------------------
package r2fft_pkg;

    localparam int MAX_POINTS   = 1024;
    localparam int LOG_MAX      = 10;
    localparam int HALF_POINTS  = MAX_POINTS / 2;
    localparam int HALF_BITS    = LOG_MAX - 1;
    localparam int IDX_BITS     = 10;
    localparam int LG_BITS      = 4;
    localparam int SAMPLE_BITS  = 16;
    localparam int TW_BITS      = 16;
    localparam int TW_FRAC      = TW_BITS - 2;
    localparam int DATA_BITS    = 28;
    localparam int PROD_BITS    = TW_BITS + DATA_BITS;
    localparam int PSUM_BITS    = PROD_BITS + 1;
    localparam int TR_BITS      = PSUM_BITS - TW_FRAC;
    localparam int ASUM_BITS    = TR_BITS + 1;
    localparam logic [LG_BITS-1:0] LG_RESET = 4'd10;

    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_RUN  = 2'd1,
        REQ_READ = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    typedef logic [2*TW_BITS-1:0] tw_rom_t [HALF_POINTS];

    function automatic logic signed [DATA_BITS-1:0] sat_data(
        input logic signed [ASUM_BITS-1:0] v
    );
        logic signed [ASUM_BITS-1:0] hi;
        logic signed [ASUM_BITS-1:0] lo;
        hi = ASUM_BITS'((64'sd1 <<< (DATA_BITS - 1)) - 64'sd1);
        lo = ASUM_BITS'(-(64'sd1 <<< (DATA_BITS - 1)));
        if (v > hi)
            return hi[DATA_BITS-1:0];
        else if (v < lo)
            return lo[DATA_BITS-1:0];
        return v[DATA_BITS-1:0];
    endfunction

    function automatic logic [IDX_BITS-1:0] bit_rev(input logic [IDX_BITS-1:0] v);
        logic [IDX_BITS-1:0] r;
        for (int i = 0; i < IDX_BITS; i++)
            r[IDX_BITS-1-i] = v[i];
        return r;
    endfunction

    function automatic tw_rom_t build_tw();
        tw_rom_t     rom;
        logic [63:0] pi_q30;
        logic [63:0] one_q30;
        logic [63:0] kk;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] tc;
        logic [63:0] ts;
        logic signed [63:0] ac;
        logic signed [63:0] as_v;
        logic [63:0] c;
        logic [63:0] s;
        logic [63:0] cs;
        logic        neg;
        pi_q30  = 64'd3373259426;
        one_q30 = 64'd1073741824;
        for (int k = 0; k < HALF_POINTS; k++) begin
            kk  = 64'(k);
            neg = 1'b0;
            if (4 * k > MAX_POINTS) begin
                kk  = 64'(HALF_POINTS - k);
                neg = 1'b1;
            end
            x  = (2 * pi_q30 * kk + 64'(HALF_POINTS)) / 64'(MAX_POINTS);
            x2 = (x * x) >> 30;
            tc = one_q30;
            ts = x;
            ac = $signed(tc);
            as_v = $signed(ts);
            for (int n = 1; n <= 14; n++) begin
                tc = ((tc * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
                ts = ((ts * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    ac   = ac - $signed(tc);
                    as_v = as_v - $signed(ts);
                end
                else begin
                    ac   = ac + $signed(tc);
                    as_v = as_v + $signed(ts);
                end
            end
            if (ac < 0) ac = 0;
            if (ac > $signed(one_q30)) ac = $signed(one_q30);
            if (as_v < 0) as_v = 0;
            if (as_v > $signed(one_q30)) as_v = $signed(one_q30);
            c  = ($unsigned(ac) + (64'd1 << (29 - TW_FRAC))) >> (30 - TW_FRAC);
            s  = ($unsigned(as_v) + (64'd1 << (29 - TW_FRAC))) >> (30 - TW_FRAC);
            cs = neg ? (64'd0 - c) : c;
            rom[k] = {cs[TW_BITS-1:0], s[TW_BITS-1:0]};
        end
        return rom;
    endfunction

    localparam tw_rom_t TW_ROM = build_tw();

endpackage

### src/r2fft_ifs.sv
// ----------------------------------------------------------------------------
// r2fft interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface r2fft_req_if;
    import r2fft_pkg::*;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    req_type;
    logic [IDX_BITS-1:0]           index;
    logic signed [SAMPLE_BITS-1:0] sample;
    modport source (output valid, req_type, index, sample, input ready);
    modport sink   (input valid, req_type, index, sample, output ready);
endinterface

interface r2fft_rsp_if;
    import r2fft_pkg::*;
    logic                        valid;
    logic                        ready;
    logic                        status;
    logic signed [DATA_BITS-1:0] bin_real;
    logic signed [DATA_BITS-1:0] bin_imag;
    modport source (output valid, status, bin_real, bin_imag, input ready);
    modport sink   (input valid, status, bin_real, bin_imag, output ready);
endinterface

interface r2fft_cfg_if;
    import r2fft_pkg::*;
    logic               valid;
    logic               ready;
    logic [LG_BITS-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### src/radix2_fft_top.sv
// ----------------------------------------------------------------------------
// radix2_fft_top
// In-place radix-2 decimation-in-time FFT over a 1024-entry complex store.
// ----------------------------------------------------------------------------
// Load and out-of-range transactions are answered straight from the idle
// state; good reads first pass through ST_READ for the synchronous store
// read. In a run each butterfly goes through read, multiply, round, write
// a and write b on the single-write-port store. The response register lets
// a new transaction enter while the previous response is being taken.
module radix2_fft_top
    import r2fft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    r2fft_req_if.sink   req,
    r2fft_rsp_if.source rsp,
    r2fft_cfg_if.sink   cfg
);
    `include "assert_macros.svh"

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_BF_RD,
        ST_BF_MUL,
        ST_BF_RND,
        ST_BF_WA,
        ST_BF_WB
    } state_t;

    localparam int MEM_BITS = 2 * DATA_BITS;

    logic [MEM_BITS-1:0] mem [MAX_POINTS];

    state_t                      state_reg;
    logic [LG_BITS-1:0]          lg_cfg_reg;
    logic                        out_valid_reg;
    logic                        out_status_reg;
    logic signed [DATA_BITS-1:0] out_re_reg;
    logic signed [DATA_BITS-1:0] out_im_reg;
    logic [LG_BITS-1:0]          stage_reg;
    logic [HALF_BITS-1:0]        cnt_reg;
    logic [IDX_BITS-1:0]         a_addr_reg;
    logic [IDX_BITS-1:0]         b_addr_reg;
    logic [MEM_BITS-1:0]         rd_a_reg;
    logic [MEM_BITS-1:0]         rd_b_reg;
    logic [2*TW_BITS-1:0]        tw_reg;
    logic signed [PROD_BITS-1:0] p_cr_reg, p_si_reg, p_ci_reg, p_sr_reg;
    logic signed [TR_BITS-1:0]   tr_reg, ti_reg;
    logic [MEM_BITS-1:0]         wb_data_reg;

    logic [LG_BITS-1:0]  lg;
    logic [IDX_BITS-1:0] n_pts;
    logic                idx_bad;
    logic                accept;
    logic [IDX_BITS-1:0] hmask;
    logic [IDX_BITS-1:0] cnt_ext;
    logic [IDX_BITS-1:0] a_next;
    logic [IDX_BITS-1:0] k_full;
    logic [IDX_BITS-1:0] load_pos;
    logic                last_cnt;
    logic                last_stage;

    logic                rd_en;
    logic [IDX_BITS-1:0] rd_addr_a;
    logic                wr_en;
    logic [IDX_BITS-1:0] wr_addr;
    logic [MEM_BITS-1:0] wr_data;

    logic signed [DATA_BITS-1:0] ar, ai, br, bi;
    logic signed [TW_BITS-1:0]   tw_c, tw_s;
    logic signed [PSUM_BITS-1:0] sum_r, sum_i;
    logic signed [PSUM_BITS-1:0] sh_r, sh_i;
    logic signed [DATA_BITS-1:0] a_re_new, a_im_new, b_re_new, b_im_new;
    logic signed [DATA_BITS-1:0] ld_sample;

    always_comb
    begin
        lg = lg_cfg_reg;
        if (lg < LG_BITS'(1))
            lg = LG_BITS'(1);
        else if (lg > LG_BITS'(LOG_MAX))
            lg = LG_BITS'(LOG_MAX);
    end

    assign n_pts   = IDX_BITS'((IDX_BITS+1)'(1) << lg);
    assign idx_bad = (lg != LG_BITS'(LOG_MAX)) && (req.index >= n_pts);

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.bin_real = out_re_reg;
    assign rsp.bin_imag = out_im_reg;

    assign hmask      = (IDX_BITS'(1) << stage_reg) - IDX_BITS'(1);
    assign cnt_ext    = IDX_BITS'(cnt_reg);
    assign a_next     = ((cnt_ext & ~hmask) << 1) | (cnt_ext & hmask);
    assign k_full     = (cnt_ext & hmask) << (LG_BITS'(LOG_MAX - 1) - stage_reg);
    assign last_cnt   = cnt_ext == ((IDX_BITS'(1) << (lg - LG_BITS'(1))) - IDX_BITS'(1));
    assign last_stage = stage_reg == (lg - LG_BITS'(1));
    assign load_pos   = bit_rev(req.index) >> (LG_BITS'(LOG_MAX) - lg);
    assign ld_sample  = DATA_BITS'(req.sample);

    assign ar   = rd_a_reg[MEM_BITS-1:DATA_BITS];
    assign ai   = rd_a_reg[DATA_BITS-1:0];
    assign br   = rd_b_reg[MEM_BITS-1:DATA_BITS];
    assign bi   = rd_b_reg[DATA_BITS-1:0];
    assign tw_c = tw_reg[2*TW_BITS-1:TW_BITS];
    assign tw_s = tw_reg[TW_BITS-1:0];

    assign sum_r = PSUM_BITS'(p_cr_reg) + PSUM_BITS'(p_si_reg)
                 + PSUM_BITS'(1 << (TW_FRAC - 1));
    assign sum_i = PSUM_BITS'(p_ci_reg) - PSUM_BITS'(p_sr_reg)
                 + PSUM_BITS'(1 << (TW_FRAC - 1));
    assign sh_r  = sum_r >>> TW_FRAC;
    assign sh_i  = sum_i >>> TW_FRAC;

    assign a_re_new = sat_data(ASUM_BITS'(ar) + ASUM_BITS'(tr_reg));
    assign a_im_new = sat_data(ASUM_BITS'(ai) + ASUM_BITS'(ti_reg));
    assign b_re_new = sat_data(ASUM_BITS'(ar) - ASUM_BITS'(tr_reg));
    assign b_im_new = sat_data(ASUM_BITS'(ai) - ASUM_BITS'(ti_reg));

    always_comb
    begin
        rd_en     = 1'b0;
        rd_addr_a = a_next;
        wr_en     = 1'b0;
        wr_addr   = a_addr_reg;
        wr_data   = {a_re_new, a_im_new};
        unique case (state_reg)
            ST_IDLE:
            begin
                rd_addr_a = req.index;
                rd_en     = accept && (req.req_type == REQ_READ) && !idx_bad;
                wr_addr   = load_pos;
                wr_data   = {ld_sample, DATA_BITS'(0)};
                wr_en     = accept && (req.req_type == REQ_LOAD) && !idx_bad;
            end
            ST_BF_RD:
            begin
                rd_en = 1'b1;
            end
            ST_BF_WA:
            begin
                wr_en = 1'b1;
            end
            ST_BF_WB:
            begin
                wr_en   = 1'b1;
                wr_addr = b_addr_reg;
                wr_data = wb_data_reg;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[a_next | hmask + IDX_BITS'(1) - IDX_BITS'(1) & ~hmask
                            | (IDX_BITS'(1) << stage_reg) | a_next];
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_BF_RD:
            begin
                a_addr_reg <= a_next;
                b_addr_reg <= a_next | (IDX_BITS'(1) << stage_reg);
                tw_reg     <= TW_ROM[k_full[HALF_BITS-1:0]];
            end
            ST_BF_MUL:
            begin
                p_cr_reg <= PROD_BITS'(tw_c) * PROD_BITS'(br);
                p_si_reg <= PROD_BITS'(tw_s) * PROD_BITS'(bi);
                p_ci_reg <= PROD_BITS'(tw_c) * PROD_BITS'(bi);
                p_sr_reg <= PROD_BITS'(tw_s) * PROD_BITS'(br);
            end
            ST_BF_RND:
            begin
                tr_reg <= sh_r[TR_BITS-1:0];
                ti_reg <= sh_i[TR_BITS-1:0];
            end
            ST_BF_WA:
            begin
                wb_data_reg <= {b_re_new, b_im_new};
            end
            default:
            begin
                tr_reg <= tr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lg_cfg_reg     <= LG_RESET;
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            out_status_reg <= 1'b0;
            out_re_reg     <= '0;
            out_im_reg     <= '0;
            stage_reg      <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                lg_cfg_reg <= cfg.data;
            if (out_valid_reg && rsp.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        out_status_reg <= 1'b0;
                        out_re_reg     <= '0;
                        out_im_reg     <= '0;
                        unique case (req.req_type)
                            REQ_LOAD:
                            begin
                                out_valid_reg  <= 1'b1;
                                out_status_reg <= idx_bad;
                            end
                            REQ_READ:
                            begin
                                if (idx_bad)
                                begin
                                    out_valid_reg  <= 1'b1;
                                    out_status_reg <= 1'b1;
                                end
                                else
                                    state_reg <= ST_READ;
                            end
                            REQ_RUN:
                            begin
                                stage_reg <= '0;
                                cnt_reg   <= '0;
                                state_reg <= ST_BF_RD;
                            end
                            default:
                            begin
                                out_valid_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_READ:
                begin
                    out_valid_reg <= 1'b1;
                    out_re_reg    <= ar;
                    out_im_reg    <= ai;
                    state_reg     <= ST_IDLE;
                end
                ST_BF_RD:  state_reg <= ST_BF_MUL;
                ST_BF_MUL: state_reg <= ST_BF_RND;
                ST_BF_RND: state_reg <= ST_BF_WA;
                ST_BF_WA:  state_reg <= ST_BF_WB;
                ST_BF_WB:
                begin
                    if (last_cnt)
                    begin
                        cnt_reg <= '0;
                        if (last_stage)
                        begin
                            out_valid_reg <= 1'b1;
                            state_reg     <= ST_IDLE;
                        end
                        else
                        begin
                            stage_reg <= stage_reg + LG_BITS'(1);
                            state_reg <= ST_BF_RD;
                        end
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + HALF_BITS'(1);
                        state_reg <= ST_BF_RD;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `ASSERT_IMPLIES(a_busy_no_rsp, clk, rst_n, state_reg != ST_IDLE, !out_valid_reg,
        "response pending while busy")
    `ASSERT_IMPLIES(a_bf_pair, clk, rst_n, state_reg == ST_BF_WA,
        ((a_addr_reg & (IDX_BITS'(1) << stage_reg)) == '0)
        && (b_addr_reg == (a_addr_reg | (IDX_BITS'(1) << stage_reg))),
        "butterfly pair addresses inconsistent")
    `ASSERT_IMPLIES(a_wb_after_wa, clk, rst_n, state_reg == ST_BF_WB,
        $past(state_reg) == ST_BF_WA, "write of b not preceded by write of a")
    `ASSERT_NEVER(a_stage_range, clk, rst_n,
        (state_reg == ST_BF_RD) && (stage_reg >= lg), "stage beyond transform size")

endmodule
